FILE: rtl/core/hds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types and constants for the half-resolution 3x3 downsampler.
// ----------------------------------------------------------------------------
package hds_pkg;

    // default sizes of the frame store
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_CHANNEL_BITS = 16;

    // fixed field widths
    localparam int CH_W       = 16;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_CH     = 4;

    // signed width of a source coordinate relative to the source origin
    localparam int REL_W = 20;

    // x/10 == (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2**22
    localparam logic [19:0] DIV10_MUL   = 20'd838861;
    localparam int          DIV10_SHIFT = 23;

    // item modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    // neighborhood tap offsets
    localparam logic [1:0] TAP_MID  = 2'd1;
    localparam logic [1:0] TAP_LAST = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_ORIGIN_X = 3'd0,
        CFG_SRC_ORIGIN_Y = 3'd1,
        CFG_SRC_WIDTH    = 3'd2,
        CFG_SRC_HEIGHT   = 3'd3,
        CFG_DST_ORIGIN_X = 3'd4,
        CFG_DST_ORIGIN_Y = 3'd5
    } t_cfg_idx;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_DIV,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic       wr;        // store the input pixel
        logic       start;     // latch neighborhood base, clear sums
        logic       rd;        // read one tap
        logic [1:0] dx;        // tap column offset
        logic [1:0] dy;        // tap row offset
        logic       acc_en;    // add the read data to the sums
        logic       acc_ctr;   // read data is the center tap
        logic       mul;       // reciprocal multiply of the rounded sums
        logic       out_load;  // load the result register
    } t_dp_cmd;

endpackage

FILE: rtl/core/hds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_if
// Valid/ready channels for load/compute items and for result items.
// ----------------------------------------------------------------------------
interface hds_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [hds_pkg::POS_W-1:0]     col;
    logic [hds_pkg::POS_W-1:0]     row;
    logic [hds_pkg::CH_W-1:0]      in_ch0;
    logic [hds_pkg::CH_W-1:0]      in_ch1;
    logic [hds_pkg::CH_W-1:0]      in_ch2;
    logic [hds_pkg::CH_W-1:0]      in_ch3;

    modport source (output valid, mode, col, row, in_ch0, in_ch1, in_ch2, in_ch3,
                    input ready);
    modport sink   (input valid, mode, col, row, in_ch0, in_ch1, in_ch2, in_ch3,
                    output ready);
endinterface

interface hds_out_if;
    logic                          valid;
    logic                          ready;
    logic [hds_pkg::CH_W-1:0]      out_ch0;
    logic [hds_pkg::CH_W-1:0]      out_ch1;
    logic [hds_pkg::CH_W-1:0]      out_ch2;
    logic [hds_pkg::CH_W-1:0]      out_ch3;

    modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, input ready);
    modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3, output ready);
endinterface

FILE: rtl/core/hds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_ctrl
// Sequencer: steps the nine neighborhood reads, the sum, the divide and the
// hand-off into the result register.
// ----------------------------------------------------------------------------
module hds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hds_pkg::t_dp_cmd o_cmd
);

    hds_pkg::t_state r_state, n_state;
    logic [1:0]      r_dx, n_dx;
    logic [1:0]      r_dy, n_dy;
    logic            r_acc_v, n_acc_v;
    logic            r_acc_ctr, n_acc_ctr;
    logic            r_out_valid, n_out_valid;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hds_pkg::S_IDLE;
            r_dx        <= '0;
            r_dy        <= '0;
            r_acc_v     <= 1'b0;
            r_acc_ctr   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_acc_v     <= n_acc_v;
            r_acc_ctr   <= n_acc_ctr;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_acc_v    = r_acc_v;
        n_acc_ctr  = r_acc_ctr;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hds_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == hds_pkg::MODE_COMPUTE) begin
                        o_cmd.start = 1'b1;
                        n_dx        = '0;
                        n_dy        = '0;
                        n_acc_v     = 1'b0;
                        n_state     = hds_pkg::S_READ;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            hds_pkg::S_READ: begin
                // read one tap, sum the one read last cycle
                o_cmd.rd      = 1'b1;
                o_cmd.dx      = r_dx;
                o_cmd.dy      = r_dy;
                o_cmd.acc_en  = r_acc_v;
                o_cmd.acc_ctr = r_acc_ctr;
                n_acc_v       = 1'b1;
                n_acc_ctr     = (r_dx == hds_pkg::TAP_MID) && (r_dy == hds_pkg::TAP_MID);
                if (r_dx == hds_pkg::TAP_LAST) begin
                    n_dx = '0;
                    if (r_dy == hds_pkg::TAP_LAST) begin
                        n_state = hds_pkg::S_LAST;
                    end else begin
                        n_dy = r_dy + 2'd1;
                    end
                end else begin
                    n_dx = r_dx + 2'd1;
                end
            end
            hds_pkg::S_LAST: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_ctr = r_acc_ctr;
                n_acc_v       = 1'b0;
                n_state       = hds_pkg::S_DIV;
            end
            hds_pkg::S_DIV: begin
                o_cmd.mul = 1'b1;
                n_state   = hds_pkg::S_DONE;
            end
            hds_pkg::S_DONE: begin
                // wait for a free result register
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = hds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hds_pkg::S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.out_load;
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/hds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_datapath
// Configuration registers, frame memory, coordinate clamp, channel sums,
// divide by ten and the result register.
// ----------------------------------------------------------------------------
module hds_datapath #(
    parameter int MAX_WIDTH    = hds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = hds_pkg::DEF_MAX_HEIGHT,
    parameter int CHANNEL_BITS = hds_pkg::DEF_CHANNEL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hds_pkg::t_dp_cmd                  i_cmd,
    input  logic                              i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hds_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [hds_pkg::POS_W-1:0]         i_col,
    input  logic [hds_pkg::POS_W-1:0]         i_row,
    input  logic [hds_pkg::CH_W-1:0]          i_ch0,
    input  logic [hds_pkg::CH_W-1:0]          i_ch1,
    input  logic [hds_pkg::CH_W-1:0]          i_ch2,
    input  logic [hds_pkg::CH_W-1:0]          i_ch3,
    output logic [hds_pkg::CH_W-1:0]          o_ch0,
    output logic [hds_pkg::CH_W-1:0]          o_ch1,
    output logic [hds_pkg::CH_W-1:0]          o_ch2,
    output logic [hds_pkg::CH_W-1:0]          o_ch3
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = 1 << (XW + YW);
    localparam int NCH   = hds_pkg::NUM_CH;
    localparam int MW    = NCH * CHANNEL_BITS;
    localparam int AW    = CHANNEL_BITS + 4;
    localparam int PW    = AW + 20;
    localparam int RW    = hds_pkg::REL_W;

    // configuration
    logic signed [15:0] r_src_origin_x;
    logic signed [15:0] r_src_origin_y;
    logic [8:0]         r_src_width;
    logic [8:0]         r_src_height;
    logic signed [14:0] r_dst_origin_x;
    logic signed [14:0] r_dst_origin_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_origin_x <= '0;
            r_src_origin_y <= '0;
            r_src_width    <= 9'd256;
            r_src_height   <= 9'd256;
            r_dst_origin_x <= '0;
            r_dst_origin_y <= '0;
        end else if (i_cfg_we) begin
            case (hds_pkg::t_cfg_idx'(i_cfg_idx))
                hds_pkg::CFG_SRC_ORIGIN_X: r_src_origin_x <= $signed(i_cfg_data);
                hds_pkg::CFG_SRC_ORIGIN_Y: r_src_origin_y <= $signed(i_cfg_data);
                hds_pkg::CFG_SRC_WIDTH:    r_src_width    <= i_cfg_data[8:0];
                hds_pkg::CFG_SRC_HEIGHT:   r_src_height   <= i_cfg_data[8:0];
                hds_pkg::CFG_DST_ORIGIN_X: r_dst_origin_x <= $signed(i_cfg_data[14:0]);
                hds_pkg::CFG_DST_ORIGIN_Y: r_dst_origin_y <= $signed(i_cfg_data[14:0]);
                default: ;
            endcase
        end
    end

    // last valid column and row of the source area
    logic [XW-1:0] lim_x;
    logic [YW-1:0] lim_y;

    always_comb begin
        if (r_src_width == '0) begin
            lim_x = '0;
        end else if (32'(r_src_width) > 32'(MAX_WIDTH)) begin
            lim_x = XW'(MAX_WIDTH - 1);
        end else begin
            lim_x = XW'(r_src_width - 9'd1);
        end
        if (r_src_height == '0) begin
            lim_y = '0;
        end else if (32'(r_src_height) > 32'(MAX_HEIGHT)) begin
            lim_y = YW'(MAX_HEIGHT - 1);
        end else begin
            lim_y = YW'(r_src_height - 9'd1);
        end
    end

    // first tap relative to the source origin: 2*(pos+dst_origin) - src_origin - 1
    logic signed [RW-1:0] sum_x, sum_y, n_base_x, n_base_y;
    logic signed [RW-1:0] r_base_x, r_base_y;

    assign sum_x    = RW'($signed({1'b0, i_col})) + RW'(r_dst_origin_x);
    assign sum_y    = RW'($signed({1'b0, i_row})) + RW'(r_dst_origin_y);
    assign n_base_x = (sum_x <<< 1) - RW'(r_src_origin_x) - RW'(1);
    assign n_base_y = (sum_y <<< 1) - RW'(r_src_origin_y) - RW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_base_x <= n_base_x;
            r_base_y <= n_base_y;
        end
    end

    // tap coordinate, clamped to the source area
    logic signed [RW-1:0] rel_x, rel_y;
    logic [XW-1:0]        rx;
    logic [YW-1:0]        ry;

    assign rel_x = r_base_x + $signed(RW'(i_cmd.dx));
    assign rel_y = r_base_y + $signed(RW'(i_cmd.dy));

    always_comb begin
        if (rel_x < 0) begin
            rx = '0;
        end else if (rel_x > $signed(RW'(lim_x))) begin
            rx = lim_x;
        end else begin
            rx = XW'(rel_x);
        end
        if (rel_y < 0) begin
            ry = '0;
        end else if (rel_y > $signed(RW'(lim_y))) begin
            ry = lim_y;
        end else begin
            ry = YW'(rel_y);
        end
    end

    // single-port frame memory, row-major with a power-of-two row pitch
    logic [MW-1:0]      r_mem [DEPTH];
    logic [MW-1:0]      r_rd_data;
    logic               mem_we;
    logic [XW+YW-1:0]   mem_addr;
    logic [MW-1:0]      mem_wdata;

    assign mem_we    = i_cmd.wr && (32'(i_col) < 32'(MAX_WIDTH))
                                && (32'(i_row) < 32'(MAX_HEIGHT));
    assign mem_addr  = i_cmd.wr ? {YW'(i_row), XW'(i_col)} : {ry, rx};
    assign mem_wdata = {CHANNEL_BITS'(i_ch3), CHANNEL_BITS'(i_ch2),
                        CHANNEL_BITS'(i_ch1), CHANNEL_BITS'(i_ch0)};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    // per-channel sums, reciprocal multiply and result register
    logic [AW-1:0]          r_acc  [NCH];
    logic [PW-1:0]          r_prod [NCH];
    logic [hds_pkg::CH_W-1:0] r_out [NCH];
    logic [AW-1:0]          tap    [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            tap[c] = i_cmd.acc_ctr ? (AW'(r_rd_data[c*CHANNEL_BITS +: CHANNEL_BITS]) << 1)
                                   :  AW'(r_rd_data[c*CHANNEL_BITS +: CHANNEL_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCH; c++) begin
            if (i_cmd.start) begin
                r_acc[c] <= '0;
            end else if (i_cmd.acc_en) begin
                r_acc[c] <= r_acc[c] + tap[c];
            end
            if (i_cmd.mul) begin
                r_prod[c] <= PW'(r_acc[c] + AW'(5)) * PW'(hds_pkg::DIV10_MUL);
            end
            if (i_cmd.out_load) begin
                r_out[c] <= hds_pkg::CH_W'(r_prod[c] >> hds_pkg::DIV10_SHIFT);
            end
        end
    end

    assign o_ch0 = r_out[0];
    assign o_ch1 = r_out[1];
    assign o_ch2 = r_out[2];
    assign o_ch3 = r_out[3];

endmodule

FILE: rtl/core/half_downsample_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_downsample_3x3
// Four-channel frame store with a half-resolution 3x3 weighted downsampler
// (center weight 2, others 1, divided by ten with rounding).
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// i_in      in   valid/ready         mode, col, row, in_ch0..in_ch3
// o_out     out  valid/ready         out_ch0..out_ch3
// i_cfg_*   in   write enable only   register index, 16-bit data
//
// a load item is written as it is accepted; the next item is accepted in the
// following cycle; a compute item reads its nine taps one per cycle from the
// single-port frame memory, then does last sum, divide and result load; the
// next item is accepted once the result register is loaded
// a finished result waits in the output register; a following compute stalls
// only at its end if that register is still full
// synchronous reset clears control and configuration; the frame memory is not
// cleared and holds undefined data until loaded
module half_downsample_3x3 #(
    parameter int MAX_WIDTH    = hds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = hds_pkg::DEF_MAX_HEIGHT,
    parameter int CHANNEL_BITS = hds_pkg::DEF_CHANNEL_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hds_in_if.sink                         i_in,
    hds_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hds_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    hds_pkg::t_dp_cmd cmd;

    // sequencer
    hds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // memory and arithmetic
    hds_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_col      (i_in.col),
        .i_row      (i_in.row),
        .i_ch0      (i_in.in_ch0),
        .i_ch1      (i_in.in_ch1),
        .i_ch2      (i_in.in_ch2),
        .i_ch3      (i_in.in_ch3),
        .o_ch0      (o_out.out_ch0),
        .o_ch1      (o_out.out_ch1),
        .o_ch2      (o_out.out_ch2),
        .o_ch3      (o_out.out_ch3)
    );

endmodule
